>>> hw/rtl/tiled_line_quad_setup_assert.svh
// ----------------------------------------------------------------------------
// Tiled line quad setup assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef TILED_LINE_QUAD_SETUP_ASSERT_SVH
`define TILED_LINE_QUAD_SETUP_ASSERT_SVH

// check a property on the rising clock edge, off while in reset
`define TLQS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that an expression never holds
`define TLQS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`TLQS_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

>>> hw/rtl/tlqs_pkg.sv
// ----------------------------------------------------------------------------
// Tiled line quad setup package
// Register indexes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tlqs_pkg;

	localparam int REG_BITS       = 13;
	localparam int TILE_BITS      = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_TEX_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TEX_HEIGHT = 2'd1;

endpackage

`default_nettype wire

>>> hw/rtl/tlqs_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// A row of cells, one root bit per cell, with a sideband word carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module tlqs_isqrt #(
	parameter int RW = 50,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [RW-1:0]   in_rad,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [RW/2-1:0] out_root,
	output logic [SW-1:0]   out_side
);

	localparam int QW  = RW / 2;
	localparam int RMW = QW + 2;

	logic           vld_q  [QW];
	logic [RW-1:0]  rad_q  [QW];
	logic [RMW-1:0] rem_q  [QW];
	logic [QW-1:0]  root_q [QW];
	logic [SW-1:0]  side_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_cell
		logic           vld_p;
		logic [RW-1:0]  rad_p;
		logic [RMW-1:0] rem_p;
		logic [QW-1:0]  root_p;
		logic [SW-1:0]  side_p;
		logic [RMW+1:0] acc;
		logic [RMW+1:0] trial;
		logic           ge;

		if (k == 0) begin : g_head
			assign vld_p  = in_valid;
			assign rad_p  = in_rad;
			assign rem_p  = '0;
			assign root_p = '0;
			assign side_p = in_side;
		end else begin : g_link
			assign vld_p  = vld_q[k-1];
			assign rad_p  = rad_q[k-1];
			assign rem_p  = rem_q[k-1];
			assign root_p = root_q[k-1];
			assign side_p = side_q[k-1];
		end

		always_comb begin
			acc   = {rem_p, rad_p[RW-1 -: 2]};
			trial = {2'b00, root_p, 2'b01};
			ge    = (acc >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else begin
				vld_q[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rad_q[k]  <= rad_p << 2;
			rem_q[k]  <= ge ? RMW'(acc - trial) : acc[RMW-1:0];
			root_q[k] <= {root_p[QW-2:0], ge};
			side_q[k] <= side_p;
		end
	end

	assign out_valid = vld_q[QW-1];
	assign out_root  = root_q[QW-1];
	assign out_side  = side_q[QW-1];

endmodule

`default_nettype wire

>>> hw/rtl/tlqs_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// A row of cells, one quotient bit per cell, with a sideband word carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module tlqs_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [NW-1:0] out_quo,
	output logic [DW-1:0] out_rem,
	output logic [SW-1:0] out_side
);

	logic          vld_q  [NW];
	logic [NW-1:0] num_q  [NW];
	logic [DW-1:0] rem_q  [NW];
	logic [DW-1:0] den_q  [NW];
	logic [SW-1:0] side_q [NW];

	for (genvar k = 0; k < NW; k++) begin : g_cell
		logic          vld_p;
		logic [NW-1:0] num_p;
		logic [DW-1:0] rem_p;
		logic [DW-1:0] den_p;
		logic [SW-1:0] side_p;
		logic [DW:0]   acc;
		logic          ge;

		if (k == 0) begin : g_head
			assign vld_p  = in_valid;
			assign num_p  = in_num;
			assign rem_p  = '0;
			assign den_p  = in_den;
			assign side_p = in_side;
		end else begin : g_link
			assign vld_p  = vld_q[k-1];
			assign num_p  = num_q[k-1];
			assign rem_p  = rem_q[k-1];
			assign den_p  = den_q[k-1];
			assign side_p = side_q[k-1];
		end

		always_comb begin
			acc = {rem_p, num_p[NW-1]};
			ge  = (acc >= {1'b0, den_p});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else begin
				vld_q[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			num_q[k]  <= {num_p[NW-2:0], ge};
			rem_q[k]  <= ge ? DW'(acc - {1'b0, den_p}) : acc[DW-1:0];
			den_q[k]  <= den_p;
			side_q[k] <= side_p;
		end
	end

	assign out_valid = vld_q[NW-1];
	assign out_quo   = num_q[NW-1];
	assign out_rem   = rem_q[NW-1];
	assign out_side  = side_q[NW-1];

endmodule

`default_nettype wire

>>> hw/rtl/tiled_line_quad_setup.sv
// Throughput: one segment per cycle; busy stays low, start may be high every cycle.
// Latency is set by the registered stages and the chain of root and divider cells, one result bit per cell.
// Reset clears all valid flags and sets tex_width and tex_height to 1.
// Results are shown for one cycle under done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Tiled line quad setup
// Expands a line segment into the four corners of a tiled textured quad.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_line_quad_setup #(
	parameter int COORD_FRAC_BITS = 8,
	parameter int COORD_BITS      = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [COORD_BITS-1:0]         start_x,
	input  logic signed [COORD_BITS-1:0]         start_y,
	input  logic signed [COORD_BITS-1:0]         end_x,
	input  logic signed [COORD_BITS-1:0]         end_y,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tlqs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [tlqs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output logic                                 done,
	output logic signed [COORD_BITS-1:0]         c0_x,
	output logic signed [COORD_BITS-1:0]         c0_y,
	output logic signed [COORD_BITS-1:0]         c1_x,
	output logic signed [COORD_BITS-1:0]         c1_y,
	output logic signed [COORD_BITS-1:0]         c2_x,
	output logic signed [COORD_BITS-1:0]         c2_y,
	output logic signed [COORD_BITS-1:0]         c3_x,
	output logic signed [COORD_BITS-1:0]         c3_y,
	output logic [tlqs_pkg::TILE_BITS-1:0]       tile_count,
	output logic                                 degenerate
);

	localparam int F    = COORD_FRAC_BITS;
	localparam int CB   = COORD_BITS;
	localparam int RB   = tlqs_pkg::REG_BITS;
	localparam int TB   = tlqs_pkg::TILE_BITS;
	localparam int LW   = CB + 1;
	localparam int RW1  = 2 * CB + 2;
	localparam int TLW  = RB + F;
	localparam int RW2  = RB + 1 + 2 * F;
	localparam int BW   = RW2 / 2;
	localparam int PHW  = CB + RB;
	localparam int PBW  = CB + BW;
	localparam int NDW  = CB + RB + 1 + F;
	localparam int DDW  = CB + 2;
	localparam int HQW  = RB + 1 + F;
	localparam int BQW  = BW + 1;
	localparam int SUMW = ((CB > HQW) ? CB : HQW) + 3;
	localparam int TXW  = (LW > TB) ? LW : TB;
	localparam int LATENCY = 7 + LW + LW + BW + NDW;

	localparam logic signed [SUMW-1:0] CMAX = {{(SUMW-CB+1){1'b0}}, {(CB-1){1'b1}}};
	localparam logic signed [SUMW-1:0] CMIN = ~CMAX;

	typedef struct packed {
		logic [CB-1:0] sx;
		logic [CB-1:0] sy;
		logic [CB-1:0] ex;
		logic [CB-1:0] ey;
		logic [CB-1:0] ax;
		logic [CB-1:0] ay;
		logic [LW-1:0] len;
		logic [TB-1:0] tiles;
		logic          negx;
		logic          negy;
		logic          posy;
		logic          degen;
	} side_t;

	localparam int SW = $bits(side_t);

	function automatic logic signed [SUMW-1:0] ext(input logic [CB-1:0] v);
		ext = $signed({{(SUMW-CB){v[CB-1]}}, v});
	endfunction

	function automatic logic [CB-1:0] sat(input logic signed [SUMW-1:0] v);
		if (v > CMAX) begin
			sat = CMAX[CB-1:0];
		end else if (v < CMIN) begin
			sat = CMIN[CB-1:0];
		end else begin
			sat = v[CB-1:0];
		end
	endfunction

	// configuration
	logic [RB-1:0] tex_width_q;
	logic [RB-1:0] tex_height_q;
	logic [RB-1:0] w_eff;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;
	assign w_eff     = (tex_width_q == '0) ? RB'(1) : tex_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= RB'(1);
			tex_height_q <= RB'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tlqs_pkg::REG_TEX_WIDTH:  tex_width_q  <= cfg_data[RB-1:0];
				tlqs_pkg::REG_TEX_HEIGHT: tex_height_q <= cfg_data[RB-1:0];
				default: ;
			endcase
		end
	end

	// front end: capture, deltas, squares, sum
	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	logic [CB-1:0]     sx_s1, sy_s1, ex_s1, ey_s1;
	side_t             side_s2, side_s3, side_s4;
	logic [2*CB-1:0]   a2_s3, b2_s3;
	logic [RW1-1:0]    sum_s4;
	logic signed [CB:0] dx, dy, ndx, ndy;
	side_t             side_d;

	always_comb begin
		dx  = $signed({ex_s1[CB-1], ex_s1}) - $signed({sx_s1[CB-1], sx_s1});
		dy  = $signed({ey_s1[CB-1], ey_s1}) - $signed({sy_s1[CB-1], sy_s1});
		ndx = -dx;
		ndy = -dy;
		side_d       = '0;
		side_d.sx    = sx_s1;
		side_d.sy    = sy_s1;
		side_d.ex    = ex_s1;
		side_d.ey    = ey_s1;
		side_d.ax    = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
		side_d.ay    = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];
		side_d.negx  = dx[CB];
		side_d.negy  = dy[CB];
		side_d.posy  = !dy[CB] && (dy != '0);
		side_d.degen = (dx == '0) && (dy == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1   <= start_x;
		sy_s1   <= start_y;
		ex_s1   <= end_x;
		ey_s1   <= end_y;
		side_s2 <= side_d;
		a2_s3   <= (2*CB)'(side_s2.ax) * (2*CB)'(side_s2.ax);
		b2_s3   <= (2*CB)'(side_s2.ay) * (2*CB)'(side_s2.ay);
		side_s3 <= side_s2;
		sum_s4  <= RW1'(a2_s3) + RW1'(b2_s3);
		side_s4 <= side_s3;
	end

	// length
	logic              len_vld;
	logic [LW-1:0]     len_root;
	logic [SW-1:0]     len_side_w;
	side_t             side_l;

	tlqs_isqrt #(.RW(RW1), .SW(SW)) u_len_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s4),
		.in_rad   (sum_s4),
		.in_side  (side_s4),
		.out_valid(len_vld),
		.out_root (len_root),
		.out_side (len_side_w)
	);

	always_comb begin
		side_l     = len_side_w;
		side_l.len = len_root;
	end

	// tile count and leftover
	logic              tile_vld;
	logic [LW-1:0]     tile_quo;
	logic [TLW-1:0]    tile_rem;
	logic [SW-1:0]     tile_side_w;
	logic [TXW-1:0]    tile_ext;
	side_t             side_t2;

	tlqs_div #(.NW(LW), .DW(TLW), .SW(SW)) u_tile_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (len_vld),
		.in_num   (len_root),
		.in_den   (TLW'(w_eff) << F),
		.in_side  (side_l),
		.out_valid(tile_vld),
		.out_quo  (tile_quo),
		.out_rem  (tile_rem),
		.out_side (tile_side_w)
	);

	always_comb begin
		tile_ext      = TXW'(tile_quo);
		side_t2       = tile_side_w;
		side_t2.tiles = (tile_ext > TXW'(16'hFFFF)) ? {TB{1'b1}} : tile_ext[TB-1:0];
	end

	// back shift root
	logic              back_vld;
	logic [BW-1:0]     back_root;
	logic [SW-1:0]     back_side_w;
	side_t             side_b;

	tlqs_isqrt #(.RW(RW2), .SW(SW)) u_back_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tile_vld),
		.in_rad   (RW2'(tile_rem) << F),
		.in_side  (side_t2),
		.out_valid(back_vld),
		.out_root (back_root),
		.out_side (back_side_w)
	);

	assign side_b = back_side_w;

	// products, then rounding dividends
	logic              vld_s5, vld_s6;
	logic [PHW-1:0]    mhx_s5, mhy_s5;
	logic [PBW-1:0]    mbx_s5, mby_s5;
	side_t             side_s5, side_s6;
	logic [NDW-1:0]    nhx_s6, nhy_s6, nbx_s6, nby_s6;
	logic [DDW-1:0]    den_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s5 <= back_vld;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		mhx_s5  <= PHW'(side_b.ay) * PHW'(tex_height_q);
		mhy_s5  <= PHW'(side_b.ax) * PHW'(tex_height_q);
		mbx_s5  <= PBW'(side_b.ax) * PBW'(back_root);
		mby_s5  <= PBW'(side_b.ay) * PBW'(back_root);
		side_s5 <= side_b;
		nhx_s6  <= (NDW'(mhx_s5) << F) + NDW'(side_s5.len);
		nhy_s6  <= (NDW'(mhy_s5) << F) + NDW'(side_s5.len);
		nbx_s6  <= (NDW'(mbx_s5) << 1) + NDW'(side_s5.len);
		nby_s6  <= (NDW'(mby_s5) << 1) + NDW'(side_s5.len);
		den_s6  <= DDW'(side_s5.len) << 1;
		side_s6 <= side_s5;
	end

	// offset division lanes
	logic              off_vld;
	logic [NDW-1:0]    qhx, qhy, qbx, qby;
	logic [SW-1:0]     off_side_w;
	side_t             side_o;

	tlqs_div #(.NW(NDW), .DW(DDW), .SW(SW)) u_hx_div (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s6), .in_num(nhx_s6), .in_den(den_s6),
		.in_side(side_s6), .out_valid(off_vld), .out_quo(qhx), .out_rem(),
		.out_side(off_side_w)
	);

	tlqs_div #(.NW(NDW), .DW(DDW), .SW(1)) u_hy_div (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s6), .in_num(nhy_s6), .in_den(den_s6),
		.in_side(1'b0), .out_valid(), .out_quo(qhy), .out_rem(), .out_side()
	);

	tlqs_div #(.NW(NDW), .DW(DDW), .SW(1)) u_bx_div (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s6), .in_num(nbx_s6), .in_den(den_s6),
		.in_side(1'b0), .out_valid(), .out_quo(qbx), .out_rem(), .out_side()
	);

	tlqs_div #(.NW(NDW), .DW(DDW), .SW(1)) u_by_div (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s6), .in_num(nby_s6), .in_den(den_s6),
		.in_side(1'b0), .out_valid(), .out_quo(qby), .out_rem(), .out_side()
	);

	assign side_o = off_side_w;

	// corners
	logic signed [SUMW-1:0] mhx, mhy, mbx, mby, hx, hy, bx, by;
	logic signed [SUMW-1:0] esx, esy, eex, eey;
	logic                   vld_s7;
	logic [CB-1:0]          c0x_s7, c0y_s7, c1x_s7, c1y_s7, c2x_s7, c2y_s7, c3x_s7, c3y_s7;
	logic [TB-1:0]          tiles_s7;
	logic                   degen_s7;

	always_comb begin
		mhx = $signed(SUMW'(qhx[HQW-1:0]));
		mhy = $signed(SUMW'(qhy[HQW-1:0]));
		mbx = $signed(SUMW'(qbx[BQW-1:0]));
		mby = $signed(SUMW'(qby[BQW-1:0]));
		hx  = side_o.posy ? -mhx : mhx;
		hy  = side_o.negx ? -mhy : mhy;
		bx  = side_o.negx ? -mbx : mbx;
		by  = side_o.negy ? -mby : mby;
		esx = ext(side_o.sx);
		esy = ext(side_o.sy);
		eex = ext(side_o.ex);
		eey = ext(side_o.ey);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= off_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (side_o.degen) begin
			c0x_s7   <= side_o.sx;
			c0y_s7   <= side_o.sy;
			c1x_s7   <= side_o.sx;
			c1y_s7   <= side_o.sy;
			c2x_s7   <= side_o.sx;
			c2y_s7   <= side_o.sy;
			c3x_s7   <= side_o.sx;
			c3y_s7   <= side_o.sy;
			tiles_s7 <= '0;
		end else begin
			c0x_s7   <= sat(esx + hx - bx);
			c0y_s7   <= sat(esy + hy - by);
			c1x_s7   <= sat(eex + hx - bx);
			c1y_s7   <= sat(eey + hy - by);
			c2x_s7   <= sat(eex - hx - bx);
			c2y_s7   <= sat(eey - hy - by);
			c3x_s7   <= sat(esx - hx - bx);
			c3y_s7   <= sat(esy - hy - by);
			tiles_s7 <= side_o.tiles;
		end
		degen_s7 <= side_o.degen;
	end

	assign done       = vld_s7;
	assign c0_x       = c0x_s7;
	assign c0_y       = c0y_s7;
	assign c1_x       = c1x_s7;
	assign c1_y       = c1y_s7;
	assign c2_x       = c2x_s7;
	assign c2_y       = c2y_s7;
	assign c3_x       = c3x_s7;
	assign c3_y       = c3y_s7;
	assign tile_count = tiles_s7;
	assign degenerate = degen_s7;

endmodule

`default_nettype wire

>>> hw/rtl/tlqs_checker.sv
// ----------------------------------------------------------------------------
// Tiled line quad setup checker
// Port-level timing and result checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tiled_line_quad_setup_assert.svh"

module tlqs_checker #(
	parameter int COORD_BITS = 24,
	parameter int LATENCY    = 118
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [COORD_BITS-1:0]          c0_x,
	input logic [COORD_BITS-1:0]          c1_x,
	input logic [COORD_BITS-1:0]          c2_x,
	input logic [COORD_BITS-1:0]          c3_x,
	input logic [tlqs_pkg::TILE_BITS-1:0] tile_count,
	input logic                           degenerate
);

	`TLQS_ASSERT(a_word_out, clk, arst_n, (start && !busy) |-> ##LATENCY done, "word lost")
	`TLQS_ASSERT(a_no_extra, clk, arst_n, done |-> $past(start && !busy, LATENCY), "extra word")
	`TLQS_ASSERT(a_degen, clk, arst_n, (done && degenerate) |-> (tile_count == '0 && c1_x == c0_x && c2_x == c0_x && c3_x == c0_x), "degenerate word not collapsed")
	`TLQS_ASSERT_NEVER(a_busy, clk, arst_n, busy, "busy raised")

endmodule

bind tiled_line_quad_setup tlqs_checker #(
	.COORD_BITS(COORD_BITS),
	.LATENCY   (LATENCY)
) u_tlqs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.c0_x      (c0_x),
	.c1_x      (c1_x),
	.c2_x      (c2_x),
	.c3_x      (c3_x),
	.tile_count(tile_count),
	.degenerate(degenerate)
);

`default_nettype wire

>>> verif/tb_tiled_line_quad_setup.sv
// ----------------------------------------------------------------------------
// Tiled line quad setup testbench
// Sends line segments through the quad setup block, predicts each quad from
// the segment and the texture size, and checks every corner, the tile count
// and the degenerate flag against the result under done. Texture width and
// height are rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_tiled_line_quad_setup;

	localparam int FRAC = 8;
	localparam int CB = 24;
	localparam int LAT = 3 * CB + 2 * FRAC + 30;
	localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;

	typedef struct {
		logic [CB-1:0] cx [8];
		logic [tlqs_pkg::TILE_BITS-1:0] tiles;
		logic degen;
	} quad_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tlqs_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [tlqs_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
	logic done;
	logic signed [CB-1:0] c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y;
	logic [tlqs_pkg::TILE_BITS-1:0] tile_count;
	logic degenerate;

	quad_t quad_q [$];
	logic [tlqs_pkg::REG_BITS-1:0] tex_w = 1, tex_h = 1;
	int errors = 0;
	int n_segs = 0, n_quads = 0, n_degen = 0, n_sat = 0;
	bit gaps_on = 1'b1;

	tiled_line_quad_setup u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done),
		.c0_x(c0_x), .c0_y(c0_y), .c1_x(c1_x), .c1_y(c1_y),
		.c2_x(c2_x), .c2_y(c2_y), .c3_x(c3_x), .c3_y(c3_y),
		.tile_count(tile_count), .degenerate(degenerate)
	);

	always #1 clk = ~clk;

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint round_div(bit neg, longint unsigned num, longint unsigned den);
		longint unsigned q = (2 * num + den) / (2 * den);
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [CB-1:0] clamp(longint v);
		if (v > CMAX) v = CMAX;
		if (v < CMIN) v = CMIN;
		return v[CB-1:0];
	endfunction

	function automatic quad_t build_quad(logic signed [CB-1:0] sxi, syi, exi, eyi);
		quad_t q;
		longint sx = sxi, sy = syi, ex = exi, ey = eyi;
		longint dx = ex - sx, dy = ey - sy;
		longint unsigned ax = dx < 0 ? -dx : dx, ay = dy < 0 ? -dy : dy;
		longint unsigned w = (tex_w == 0) ? 1 : tex_w, h = tex_h;
		longint unsigned len, tl, nt, rem, back;
		longint hx, hy, bx, by;
		if (dx == 0 && dy == 0) begin
			for (int k = 0; k < 4; k++) begin
				q.cx[2*k] = clamp(sx);
				q.cx[2*k+1] = clamp(sy);
			end
			q.tiles = 0;
			q.degen = 1'b1;
			return q;
		end
		len = root_floor(ax * ax + ay * ay);
		tl = w << FRAC;
		nt = len / tl;
		rem = len - nt * tl;
		back = root_floor(rem << FRAC);
		hx = round_div(dy > 0, (ay * h) << FRAC, 2 * len);
		hy = round_div(dx < 0, (ax * h) << FRAC, 2 * len);
		bx = round_div(dx < 0, ax * back, len);
		by = round_div(dy < 0, ay * back, len);
		q.cx[0] = clamp(sx + hx - bx);
		q.cx[1] = clamp(sy + hy - by);
		q.cx[2] = clamp(ex + hx - bx);
		q.cx[3] = clamp(ey + hy - by);
		q.cx[4] = clamp(ex - hx - bx);
		q.cx[5] = clamp(ey - hy - by);
		q.cx[6] = clamp(sx - hx - bx);
		q.cx[7] = clamp(sy - hy - by);
		q.tiles = nt > 65535 ? 16'hFFFF : nt[15:0];
		q.degen = 1'b0;
		return q;
	endfunction

	// send one segment; leaves start high so back-to-back words stay continuous
	task automatic send_seg(logic signed [CB-1:0] sx, sy, ex, ey);
		quad_t q;
		if (gaps_on) begin
			while ($urandom_range(99) < 35) begin
				start = 1'b0;
				@(negedge clk);
			end
		end
		start = 1'b1;
		start_x = sx; start_y = sy; end_x = ex; end_y = ey;
		do @(posedge clk); while (busy);
		q = build_quad(sx, sy, ex, ey);
		if (q.degen) n_degen++;
		if (q.tiles == 16'hFFFF) n_sat++;
		quad_q.push_back(q);
		n_segs++;
		@(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		wait (quad_q.size() == 0);
		@(negedge clk);
		repeat (LAT + 10) @(negedge clk);
	endtask

	task automatic write_reg(logic [tlqs_pkg::CFG_INDEX_BITS-1:0] idx,
		logic [tlqs_pkg::CFG_DATA_BITS-1:0] val);
		drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == tlqs_pkg::REG_TEX_WIDTH) tex_w = val[tlqs_pkg::REG_BITS-1:0];
		else if (idx == tlqs_pkg::REG_TEX_HEIGHT) tex_h = val[tlqs_pkg::REG_BITS-1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic check_field(string name, logic [CB-1:0] exp_v, logic [CB-1:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		quad_t q;
		logic [CB-1:0] act [8];
		if (arst_n && done) begin
			if (quad_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected quad, expected none, got tile_count %h",
					$realtime, tile_count);
			end else begin
				q = quad_q.pop_front();
				act = '{c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y};
				for (int k = 0; k < 8; k++)
					check_field($sformatf("corner %0d %s", k / 2, (k % 2) ? "y" : "x"),
						q.cx[k], act[k]);
				check_field("tile_count", CB'(q.tiles), CB'(tile_count));
				check_field("degenerate", CB'(q.degen), CB'(degenerate));
				n_quads++;
			end
		end
	end

	function automatic logic signed [CB-1:0] rnd_coord();
		return CB'($urandom);
	endfunction

	task automatic test_directed();
		logic signed [CB-1:0] mx = CMAX, mn = CMIN;
		send_seg(0, 0, 0, 0);
		send_seg(mx, mn, mx, mn);
		send_seg(mn, mn, mx, mx);
		send_seg(mx, mx, mn, mn);
		send_seg(mn, 0, mx, 0);
		send_seg(0, mx, 0, mn);
		send_seg(100, 100, 356, 100);
		send_seg(100, 100, 100, 356);
		send_seg(0, 0, 255, 0);
		send_seg(0, 0, -256, 0);
		send_seg(0, 0, 0, -1);
		send_seg(10, -20, 30, 40);
		send_seg(mx, mx, mx - 1, mx);
		send_seg(-5000, 7000, -5000, 7000);
	endtask

	task automatic test_reg_extremes();
		write_reg(tlqs_pkg::REG_TEX_WIDTH, 0);
		write_reg(tlqs_pkg::REG_TEX_HEIGHT, 0);
		send_seg(0, 0, 1000, 0);
		send_seg(0, 0, -3000, 4000);
		write_reg(tlqs_pkg::REG_TEX_WIDTH, 4096);
		write_reg(tlqs_pkg::REG_TEX_HEIGHT, 4096);
		send_seg(0, 0, 1000, 1000);
		send_seg(CMIN, CMIN, CMAX, CMAX);
		send_seg(CMAX, 0, CMAX, 10);
		write_reg(tlqs_pkg::REG_TEX_WIDTH, 16'hFFFF);
		write_reg(tlqs_pkg::REG_TEX_HEIGHT, 16'hFFFF);
		send_seg(0, 0, CMAX, 0);
		send_seg(CMIN, 0, CMIN + 77, 0);
	endtask

	task automatic random_batch(int n);
		logic signed [CB-1:0] sx, sy;
		int span;
		for (int i = 0; i < n; i++) begin
			sx = rnd_coord();
			sy = rnd_coord();
			case ($urandom_range(9))
				0, 1, 2: send_seg(sx, sy, rnd_coord(), rnd_coord());
				3: send_seg(sx, sy, sx, sy);
				default: begin
					span = (tex_w + 1) * 256 * $urandom_range(1, 4);
					send_seg(sx, sy, sx + $signed($urandom_range(0, 2 * span)) - span,
						sy + $signed($urandom_range(0, 2 * span)) - span);
				end
			endcase
		end
	endtask

	task automatic test_random();
		for (int p = 0; p < 8; p++) begin
			write_reg(tlqs_pkg::REG_TEX_WIDTH, (p % 3 == 0) ? $urandom_range(1, 16)
				: $urandom_range(1, 4096));
			write_reg(tlqs_pkg::REG_TEX_HEIGHT, $urandom_range(0, 4096));
			gaps_on = (p != 3);
			random_batch(90);
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_pause_drain();
		random_batch(20);
		drain();
		random_batch(40);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_reg_extremes();
		test_random();
		test_pause_drain();
		drain();
		$display("Sent %0d segments, checked %0d quads (%0d degenerate, %0d saturated tile counts)",
			n_segs, n_quads, n_degen, n_sat);
		$display("Covered register extremes, back-to-back and gapped traffic, and full drains");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d quads outstanding", quad_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/tlqs_pkg.sv
hw/rtl/tlqs_isqrt.sv
hw/rtl/tlqs_div.sv
hw/rtl/tiled_line_quad_setup.sv
hw/rtl/tlqs_checker.sv
verif/tb_tiled_line_quad_setup.sv
